FILE: src/salc_pkg.sv
// Shared constants and types for the set-associative LRU cache tag block.
package salc_pkg;

   localparam int MEM_ADDR_BITS  = 20;
   localparam int SET_INDEX_BITS = 6;
   localparam int OFFSET_BITS    = 4;
   localparam int WAY_BITS       = 2;

   localparam int NUM_WAYS  = 1 << WAY_BITS;
   localparam int NUM_SETS  = 1 << SET_INDEX_BITS;
   localparam int WAY_W     = (WAY_BITS > 0) ? WAY_BITS : 1;
   localparam int SET_AW    = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
   localparam int TAG_BITS  = MEM_ADDR_BITS - SET_INDEX_BITS - OFFSET_BITS;
   localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
   localparam int TAG_ROW_W = NUM_WAYS * TAG_W;
   localparam int ORDER_W   = NUM_WAYS * WAY_W;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_LOOKUP
   } salc_state_type;

   typedef struct packed {
      logic capture;
      logic resolve;
   } salc_cmd_type;

endpackage

FILE: src/salc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/salc_ctrl.sv
// Controller state machine: accepts a transaction and sequences lookup and response.
module salc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   output salc_pkg::salc_cmd_type cmd
);

   salc_pkg::salc_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      busy         = 1'b0;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         salc_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = salc_pkg::ST_LOOKUP;
            end
         end
         salc_pkg::ST_LOOKUP: begin
            busy         = 1'b1;
            cmd.resolve  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = salc_pkg::ST_IDLE;
         end
         default: begin
            state_in = salc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/salc_dp.sv
// Datapath: tag, dirty and recency memories, valid bits, way choice and counters.
module salc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  salc_pkg::salc_cmd_type cmd,
   input  logic                   req_op,
   input  logic [31:0]            req_address,
   output logic                   rsp_error,
   output logic                   rsp_hit,
   output logic [1:0]             rsp_way,
   output logic                   rsp_filled_invalid,
   output logic                   rsp_wrote_back,
   output logic [31:0]            rsp_fill_count,
   output logic [31:0]            rsp_writeback_count
);

   localparam int NW = salc_pkg::NUM_WAYS;
   localparam int WW = salc_pkg::WAY_W;
   localparam int TW = salc_pkg::TAG_W;

   logic                          op_ff;
   logic [31:0]                   addr_ff;
   logic [NW-1:0]                 valid_ff [salc_pkg::NUM_SETS];
   logic [NW-1:0]                 vrow_ff;
   logic [31:0]                   fills_ff, fills_in;
   logic [31:0]                   wbacks_ff, wbacks_in;
   logic                          err_ff, hit_ff, filled_ff, wb_ff;
   logic [1:0]                    way_ff;

   logic [salc_pkg::SET_AW-1:0]   rd_set;
   logic [salc_pkg::SET_AW-1:0]   set_idx;
   logic [TW-1:0]                 tag;
   logic                          err;
   logic [salc_pkg::TAG_ROW_W-1:0] tag_row, tag_row_new;
   logic [salc_pkg::ORDER_W-1:0]  order_raw, order, order_new;
   logic [NW-1:0]                 vrow, drow, vrow_new, drow_new;
   logic                          found, have_inv, evict, wb, miss;
   logic [WW-1:0]                 hit_way, inv_way, victim, way_sel;
   logic [WW-1:0]                 pos;
   logic                          tag_we, order_we;

   assign rd_set  = salc_pkg::SET_AW'((req_address >> salc_pkg::OFFSET_BITS)
                                      & 32'(salc_pkg::NUM_SETS - 1));
   assign set_idx = salc_pkg::SET_AW'((addr_ff >> salc_pkg::OFFSET_BITS)
                                      & 32'(salc_pkg::NUM_SETS - 1));
   assign tag     = TW'(addr_ff >> (salc_pkg::SET_INDEX_BITS + salc_pkg::OFFSET_BITS));
   assign err     = (64'(addr_ff) >> salc_pkg::MEM_ADDR_BITS) != 64'd0;

   salc_ram #(
      .WIDTH(salc_pkg::TAG_ROW_W),
      .DEPTH(salc_pkg::NUM_SETS)
   ) u_tag_ram (
      .clock  (clock),
      .wr_en  (tag_we),
      .wr_addr(set_idx),
      .wr_data(tag_row_new),
      .rd_en  (cmd.capture),
      .rd_addr(rd_set),
      .rd_data(tag_row)
   );

   salc_ram #(
      .WIDTH(salc_pkg::ORDER_W),
      .DEPTH(salc_pkg::NUM_SETS)
   ) u_order_ram (
      .clock  (clock),
      .wr_en  (order_we),
      .wr_addr(set_idx),
      .wr_data(order_new),
      .rd_en  (cmd.capture),
      .rd_addr(rd_set),
      .rd_data(order_raw)
   );

   salc_ram #(
      .WIDTH(NW),
      .DEPTH(salc_pkg::NUM_SETS)
   ) u_dirty_ram (
      .clock  (clock),
      .wr_en  (order_we),
      .wr_addr(set_idx),
      .wr_data(drow_new),
      .rd_en  (cmd.capture),
      .rd_addr(rd_set),
      .rd_data(drow)
   );

   always_comb begin
      vrow = vrow_ff;

      // A set with no valid way has never been accessed, so its order row in
      // RAM was never written and the reset order applies.
      if (vrow != '0) begin
         order = order_raw;
      end else begin
         for (int p = 0; p < NW; p++) begin
            order[p*WW +: WW] = WW'(p);
         end
      end

      // Lowest matching way wins; highest invalid way is the fill candidate.
      found   = 1'b0;
      hit_way = '0;
      for (int w = NW - 1; w >= 0; w--) begin
         if (vrow[w] && (tag_row[w*TW +: TW] == tag)) begin
            found   = 1'b1;
            hit_way = WW'(w);
         end
      end
      have_inv = 1'b0;
      inv_way  = '0;
      for (int w = 0; w < NW; w++) begin
         if (!vrow[w]) begin
            have_inv = 1'b1;
            inv_way  = WW'(w);
         end
      end

      victim = order[(NW-1)*WW +: WW];
      miss   = !found;
      evict  = miss && !have_inv;
      if (found) begin
         way_sel = hit_way;
      end else if (have_inv) begin
         way_sel = inv_way;
      end else begin
         way_sel = victim;
      end
      wb = evict && drow[victim];

      // Move the used way to the front; a missing way drops the last entry.
      pos = WW'(NW - 1);
      for (int p = NW - 1; p >= 0; p--) begin
         if (order[p*WW +: WW] == way_sel) begin
            pos = WW'(p);
         end
      end
      order_new = order;
      for (int p = 1; p < NW; p++) begin
         if (WW'(p) <= pos) begin
            order_new[p*WW +: WW] = order[(p-1)*WW +: WW];
         end
      end
      order_new[WW-1:0] = way_sel;

      tag_row_new = tag_row;
      tag_row_new[way_sel*TW +: TW] = tag;

      // A freshly filled line starts clean unless this access writes it.
      vrow_new = vrow;
      vrow_new[way_sel] = 1'b1;
      drow_new = drow;
      drow_new[way_sel] = op_ff || (found && drow[way_sel]);

      tag_we    = cmd.resolve && !err && miss;
      order_we  = cmd.resolve && !err;
      fills_in  = fills_ff + 32'(miss);
      wbacks_in = wbacks_ff + 32'(wb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < salc_pkg::NUM_SETS; s++) begin
            valid_ff[s] <= '0;
         end
         fills_ff  <= '0;
         wbacks_ff <= '0;
      end else if (order_we) begin
         valid_ff[set_idx] <= vrow_new;
         fills_ff          <= fills_in;
         wbacks_ff         <= wbacks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         addr_ff <= req_address;
         vrow_ff <= valid_ff[rd_set];
      end
      if (cmd.resolve) begin
         err_ff    <= err;
         hit_ff    <= !err && found;
         way_ff    <= err ? 2'd0 : 2'(way_sel);
         filled_ff <= !err && miss && have_inv;
         wb_ff     <= !err && wb;
      end
   end

   assign rsp_error           = err_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_way             = way_ff;
   assign rsp_filled_invalid  = filled_ff;
   assign rsp_wrote_back      = wb_ff;
   assign rsp_fill_count      = fills_ff;
   assign rsp_writeback_count = wbacks_ff;

endmodule

FILE: src/set_assoc_lru_cache_tag_model.sv
// Top level of the set-associative LRU write-back cache tag block.
//
// This block tracks the tag side of a 4-way, 64-set write-back cache over a
// 2^20-word address space: per-line valid, dirty and 10-bit tag, a per-set
// most-recent-first way order, and wrapping 32-bit counts of block fills and
// dirty writebacks. A transaction is accepted at a rising edge where start is
// high and busy is low. Each transaction has a capture step and a lookup step:
// in the first the set index addresses the tag, dirty and order RAMs (all with
// registered reads) and the set's valid bits are registered; in the second the
// ways are compared, the way is chosen, and the order row, valid and dirty bits
// and counters are written back, with the tag row on a miss. busy is high for
// the lookup step only. The result appears on the rsp_ ports for exactly one
// cycle, marked by rsp_valid, in the cycle after the lookup; a new transaction
// may be accepted in that same cycle. The receiver cannot stall
// the response. The counts on the result show their values after the
// transaction. An address at or above 2^20 returns error with all other flags
// and the way at zero, and leaves every piece of state unchanged. On a miss the
// highest-numbered invalid way is filled; when none is invalid, the least
// recent way is evicted. Valid bits and counters come out of reset cleared at
// once, with no clearing pass. The dirty bits and the way order live in RAM
// with no reset: a set with no valid way has never been accessed, so the
// reset order is used for it, and a line's dirty bit is rewritten whenever the
// line is filled.
module set_assoc_lru_cache_tag_model (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   output logic        rsp_error,
   output logic        rsp_hit,
   output logic [1:0]  rsp_way,
   output logic        rsp_filled_invalid,
   output logic        rsp_wrote_back,
   output logic [31:0] rsp_fill_count,
   output logic [31:0] rsp_writeback_count
);

   // Commands from the controller to the datapath.
   salc_pkg::salc_cmd_type cmd;

   salc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .cmd      (cmd)
   );

   salc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_op             (req_op),
      .req_address        (req_address),
      .rsp_error          (rsp_error),
      .rsp_hit            (rsp_hit),
      .rsp_way            (rsp_way),
      .rsp_filled_invalid (rsp_filled_invalid),
      .rsp_wrote_back     (rsp_wrote_back),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_writeback_count(rsp_writeback_count)
   );

endmodule

FILE: src/salc_checker.sv
// Port-level checker for the cache tag block, bound to its top level.
module salc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_error,
   input logic        rsp_hit,
   input logic        rsp_filled_invalid,
   input logic        rsp_wrote_back,
   input logic [31:0] rsp_fill_count,
   input logic [31:0] rsp_writeback_count
);

   // An accepted transaction occupies exactly one busy cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("lookup did not finish in one cycle with a response");

   // Flags of a response are mutually consistent.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!(rsp_error && (rsp_hit || rsp_filled_invalid || rsp_wrote_back))
                     && !(rsp_hit && (rsp_filled_invalid || rsp_wrote_back))
                     && !(rsp_filled_invalid && rsp_wrote_back)))
      else $error("inconsistent response flags");

   // Every miss counts one fill; every dirty eviction counts one writeback.
   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(busy)) |->
         (rsp_fill_count == $past(rsp_fill_count) + 32'(!rsp_hit && !rsp_error)))
      else $error("fill count step mismatch");

   a_wb_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(busy)) |->
         (rsp_writeback_count == $past(rsp_writeback_count) + 32'(rsp_wrote_back)))
      else $error("writeback count step mismatch");

endmodule

bind set_assoc_lru_cache_tag_model salc_checker u_salc_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_error          (rsp_error),
   .rsp_hit            (rsp_hit),
   .rsp_filled_invalid (rsp_filled_invalid),
   .rsp_wrote_back     (rsp_wrote_back),
   .rsp_fill_count     (rsp_fill_count),
   .rsp_writeback_count(rsp_writeback_count)
);

FILE: tb/set_assoc_lru_cache_tag_model_tb.sv
// Self-checking testbench for the set-associative LRU write-back cache tag block.
module set_assoc_lru_cache_tag_model_tb;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 10;
   localparam int RANDOM_ACCESSES = 1800;
   // A response shows up in the cycle after the lookup cycle, so the drain after
   // the last expected response is plenty to catch a stray one.
   localparam int DRAIN_CYCLES    = 10;
   // Far beyond the slowest correct run, random gaps of the driver included.
   localparam int CYCLE_LIMIT     = 200000;
   localparam int IDLE_PERCENT    = 30;
   // Transactions accepted in this window are driven back to back.
   localparam int CALM_FIRST      = 700;
   localparam int CALM_LAST       = 1100;
   // The hot pools are small on purpose: six tags competing for four ways in
   // a few sets give a steady mix of hits, clean evictions and writebacks.
   localparam int HOT_SETS        = 4;
   localparam int HOT_TAGS        = 6;
   localparam int POOL_REFRESH    = 300;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } access_op_type;

   typedef struct {
      access_op_type op;
      logic [31:0]   address;
   } cache_access_type;

   typedef struct {
      logic        error;
      logic        hit;
      logic [1:0]  way;
      logic        filled_invalid;
      logic        wrote_back;
      logic [31:0] fill_count;
      logic [31:0] writeback_count;
   } lookup_result_type;

   // Every input of the block starts at a known value, reset included.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        start       = 1'b0;
   logic        req_op      = 1'b0;
   logic [31:0] req_address = '0;

   logic        busy;
   logic        rsp_valid;
   logic        rsp_error;
   logic        rsp_hit;
   logic [1:0]  rsp_way;
   logic        rsp_filled_invalid;
   logic        rsp_wrote_back;
   logic [31:0] rsp_fill_count;
   logic [31:0] rsp_writeback_count;

   set_assoc_lru_cache_tag_model dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_address         (req_address),
      .rsp_valid           (rsp_valid),
      .rsp_error           (rsp_error),
      .rsp_hit             (rsp_hit),
      .rsp_way             (rsp_way),
      .rsp_filled_invalid  (rsp_filled_invalid),
      .rsp_wrote_back      (rsp_wrote_back),
      .rsp_fill_count      (rsp_fill_count),
      .rsp_writeback_count (rsp_writeback_count)
   );

   // Transactions waiting to be driven, and the lookups the block still owes.
   cache_access_type  access_q[$];
   lookup_result_type expected_lookups[$];

   int   stimulus_total = 0;
   int   accepted_count = 0;
   int   fail_count     = 0;
   int   cycle_count    = 0;
   logic item_taken     = 1'b0;

   // Our own copy of the cache tag state, updated as each transaction is
   // accepted. The tag store is cleared here, but a tag is only looked at
   // when its valid bit is set, so the cleared value is never relied on.
   logic line_valid [salc_pkg::NUM_SETS][salc_pkg::NUM_WAYS];
   logic line_dirty [salc_pkg::NUM_SETS][salc_pkg::NUM_WAYS];
   logic [salc_pkg::TAG_W-1:0] line_tag [salc_pkg::NUM_SETS][salc_pkg::NUM_WAYS];
   // Position 0 of each row is the most recently used way.
   logic [salc_pkg::WAY_W-1:0] mru_order [salc_pkg::NUM_SETS][salc_pkg::NUM_WAYS];
   logic [31:0] fill_total;
   logic [31:0] writeback_total;

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Builds a word address from its tag, set index and word offset.
   function automatic logic [31:0] tag_address(input logic [31:0] tag,
                                               input logic [31:0] set_idx,
                                               input logic [31:0] offset);
      return (tag << (salc_pkg::SET_INDEX_BITS + salc_pkg::OFFSET_BITS))
             | (set_idx << salc_pkg::OFFSET_BITS) | offset;
   endfunction

   // Works out the response to one access and moves the tag state forward.
   function automatic lookup_result_type predict_lookup(input access_op_type op,
                                                        input logic [31:0] address);
      lookup_result_type           res;
      logic [salc_pkg::TAG_W-1:0]  tag;
      logic [salc_pkg::SET_AW-1:0] set_idx;
      logic [salc_pkg::WAY_W-1:0]  way_sel;
      logic                        found;
      logic                        have_invalid;
      int                          pos;
      res.error          = (address >> salc_pkg::MEM_ADDR_BITS) != 0;
      res.hit            = 1'b0;
      res.way            = '0;
      res.filled_invalid = 1'b0;
      res.wrote_back     = 1'b0;
      // An out-of-range address leaves every piece of state alone.
      if (!res.error) begin
         tag          = salc_pkg::TAG_W'(address >>
                                         (salc_pkg::SET_INDEX_BITS + salc_pkg::OFFSET_BITS));
         set_idx      = salc_pkg::SET_AW'(address >> salc_pkg::OFFSET_BITS);
         found        = 1'b0;
         have_invalid = 1'b0;
         way_sel      = '0;
         // The scan stops at the first match; until then it keeps the
         // highest-numbered invalid way seen, which is the fill choice.
         for (int w = 0; w < salc_pkg::NUM_WAYS && !found; w++) begin
            if (line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
               found   = 1'b1;
               way_sel = salc_pkg::WAY_W'(w);
            end else if (!line_valid[set_idx][w]) begin
               have_invalid = 1'b1;
               way_sel      = salc_pkg::WAY_W'(w);
            end
         end
         if (found) begin
            res.hit = 1'b1;
         end else begin
            if (have_invalid) begin
               res.filled_invalid = 1'b1;
            end else begin
               // Evict the least recent way; a dirty victim is written back.
               way_sel = mru_order[set_idx][salc_pkg::NUM_WAYS - 1];
               if (line_dirty[set_idx][way_sel]) begin
                  res.wrote_back               = 1'b1;
                  writeback_total              = writeback_total + 32'd1;
                  line_dirty[set_idx][way_sel] = 1'b0;
               end
            end
            fill_total                   = fill_total + 32'd1;
            line_tag[set_idx][way_sel]   = tag;
            line_valid[set_idx][way_sel] = 1'b1;
         end
         // Move the used way to the front. A way missing from the row cannot
         // happen from reset; if it did, the whole row would shift back.
         pos = salc_pkg::NUM_WAYS - 1;
         for (int p = salc_pkg::NUM_WAYS - 1; p >= 0; p--) begin
            if (mru_order[set_idx][p] == way_sel) pos = p;
         end
         for (int p = pos; p > 0; p--) begin
            mru_order[set_idx][p] = mru_order[set_idx][p - 1];
         end
         mru_order[set_idx][0] = way_sel;
         if (op == OP_WRITE) line_dirty[set_idx][way_sel] = 1'b1;
         res.way = way_sel;
      end
      res.fill_count      = fill_total;
      res.writeback_count = writeback_total;
      return res;
   endfunction

   function automatic void check_field(input string name,
                                       input logic [31:0] expected_val,
                                       input logic [31:0] actual_val);
      if (expected_val !== actual_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, expected_val, actual_val);
         fail_count++;
      end
   endfunction

   // Driver. Inputs change on the falling edge only. A transaction stays on
   // the request ports until the monitor has seen it accepted; only then may
   // the next one go out or the driver take a random pause. Within the calm
   // window it never pauses, so the block also sees back-to-back traffic.
   always @(negedge clock) begin : access_driver
      logic             idle_now;
      cache_access_type next_access;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (accepted_count >= CALM_FIRST && accepted_count < CALM_LAST) begin
            idle_now = 1'b0;
         end else begin
            idle_now = $urandom_range(99) < IDLE_PERCENT;
         end
         if (access_q.size() == 0 || idle_now) begin
            start <= 1'b0;
         end else begin
            next_access = access_q.pop_front();
            start       <= 1'b1;
            req_op      <= next_access.op;
            req_address <= next_access.address;
         end
      end
   end

   // Monitor. Everything is sampled on the rising edge, where the block's
   // outputs still hold their values from the cycle that is ending. A
   // response is checked before the transaction accepted at the same edge is
   // predicted, so the queue always holds responses in issue order.
   always @(posedge clock) begin : lookup_monitor
      lookup_result_type exp_res;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_lookups.size() == 0) begin
               $error("Response with no transaction outstanding");
               fail_count++;
            end else begin
               exp_res = expected_lookups.pop_front();
               check_field("error", 32'(exp_res.error), 32'(rsp_error));
               check_field("hit", 32'(exp_res.hit), 32'(rsp_hit));
               check_field("way", 32'(exp_res.way), 32'(rsp_way));
               check_field("filled_invalid", 32'(exp_res.filled_invalid),
                           32'(rsp_filled_invalid));
               check_field("wrote_back", 32'(exp_res.wrote_back), 32'(rsp_wrote_back));
               check_field("fill_count", exp_res.fill_count, rsp_fill_count);
               check_field("writeback_count", exp_res.writeback_count,
                           rsp_writeback_count);
            end
         end
         if (start && !busy) begin
            expected_lookups.push_back(predict_lookup(access_op_type'(req_op),
                                                      req_address));
            accepted_count++;
         end
      end
      item_taken <= !reset && start && !busy;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] hot_tag [HOT_TAGS];
      logic [31:0] hot_set [HOT_SETS];
      logic [31:0] addr;
      int          pick;

      for (int s = 0; s < salc_pkg::NUM_SETS; s++) begin
         for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
            line_valid[s][w] = 1'b0;
            line_dirty[s][w] = 1'b0;
            line_tag[s][w]   = '0;
            mru_order[s][w]  = salc_pkg::WAY_W'(w);
         end
      end
      fill_total      = '0;
      writeback_total = '0;

      // Directed part, all in set 0 unless noted. The first access fills the
      // highest invalid way, the next few fill the set, then a hit reorders
      // it and later misses evict the least recent way, dirty and clean.
      access_q.push_back(cache_access_type'{OP_READ,  tag_address(0, 0, 0)});
      access_q.push_back(cache_access_type'{OP_WRITE, tag_address(0, 0, 5)});
      access_q.push_back(cache_access_type'{OP_WRITE, tag_address(1, 0, 0)});
      access_q.push_back(cache_access_type'{OP_READ,  tag_address(2, 0, 15)});
      access_q.push_back(cache_access_type'{OP_READ,  tag_address(3, 0, 0)});
      access_q.push_back(cache_access_type'{OP_READ,  tag_address(0, 0, 1)});
      access_q.push_back(cache_access_type'{OP_READ,  tag_address(4, 0, 0)});
      access_q.push_back(cache_access_type'{OP_WRITE, tag_address(5, 0, 0)});
      // Out-of-range addresses: the lowest one and all ones (the top bit follows below).
      // None of them may disturb the set, which the following hit confirms.
      access_q.push_back(cache_access_type'{OP_WRITE, 32'h0010_0000});
      access_q.push_back(cache_access_type'{OP_READ,  32'hFFFF_FFFF});
      access_q.push_back(cache_access_type'{OP_READ,  tag_address(5, 0, 0)});
      // Highest in-range address: largest tag, last set, last word.
      access_q.push_back(cache_access_type'{OP_READ,  32'h000F_FFFF});
      access_q.push_back(cache_access_type'{OP_WRITE, 32'h000F_FFFF});
      access_q.push_back(cache_access_type'{OP_READ,  32'h8000_0000});
      access_q.push_back(cache_access_type'{OP_WRITE, tag_address(6, 0, 0)});
      access_q.push_back(cache_access_type'{OP_WRITE, tag_address(7, 0, 0)});
      access_q.push_back(cache_access_type'{OP_READ,  tag_address(0, 0, 0)});
      access_q.push_back(cache_access_type'{OP_READ,  32'h0000_0000});

      // Random part. Most accesses hit a small pool of tags and sets with a
      // random word offset; the rest are arbitrary in-range addresses and
      // out-of-range addresses with random upper bits.
      for (int i = 0; i < RANDOM_ACCESSES; i++) begin
         if (i % POOL_REFRESH == 0) begin
            foreach (hot_tag[k]) hot_tag[k] = $urandom_range((1 << salc_pkg::TAG_BITS) - 1);
            foreach (hot_set[k]) hot_set[k] = $urandom_range(salc_pkg::NUM_SETS - 1);
         end
         pick = $urandom_range(99);
         if (pick < 8) begin
            addr = $urandom;
            addr[$urandom_range(31, salc_pkg::MEM_ADDR_BITS)] = 1'b1;
         end else if (pick < 18) begin
            addr = $urandom & ((32'd1 << salc_pkg::MEM_ADDR_BITS) - 1);
         end else begin
            addr = tag_address(hot_tag[$urandom_range(HOT_TAGS - 1)],
                               hot_set[$urandom_range(HOT_SETS - 1)],
                               $urandom_range((1 << salc_pkg::OFFSET_BITS) - 1));
         end
         access_q.push_back(cache_access_type'{access_op_type'($urandom_range(1)), addr});
      end
      stimulus_total = access_q.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count < stimulus_total || expected_lookups.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
